[rtl/sha256_pkg.sv]
// Shared types and constants for the SHA-256 byte stream hasher.
// Holds the beat structs, the round constant table and the initial hash values.
// No dependencies.
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_beat_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] idx);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[idx];
	endfunction

endpackage

[rtl/sha256_queue.sv]
// Short FIFO that decouples the front end from the compression back end.
// Uses in_beat_t from sha256_pkg.
module sha256_queue import sha256_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  in_beat_t wr_data,
	output logic     full,
	input  logic     rd_en,
	output in_beat_t rd_data,
	output logic     empty
);

	in_beat_t   slot_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	assign full    = (count_q == 3'd4);
	assign empty   = (count_q == 3'd0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {2'b0, wr_en} - {2'b0, rd_en};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) full |-> !wr_en)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) empty |-> !rd_en)
		else $error("queue read while empty");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 3'd4)
		else $error("queue count out of range");

endmodule

[rtl/sha256_core.sv]
// Back end: block buffer, padding sequencer, one-round-per-cycle compression
// and digest output register. Uses types and constants from sha256_pkg.
module sha256_core import sha256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  in_beat_t  q_data,
	output logic      q_pop,
	output logic      out_valid,
	output out_beat_t out_beat,
	input  logic      out_stall
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_FOLD  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [31:0] h_q [8];
	logic [31:0] r_q [8];
	logic [31:0] w_q [16];
	logic [31:0] blk_q [16];
	logic [63:0] bits_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [3:0]  ld_q;
	logic        final_q;
	logic        spill_q;
	logic        pend_end_q;
	logic [2:0]  emit_q;
	logic        ov_q;
	out_beat_t   ob_q;

	logic [31:0] s0, s1, w_new, t1, t2, e, a, ld_word;
	logic [31:0] bsig0, bsig1, ch, maj;
	logic        pad_done_blk;

	assign e     = r_q[4];
	assign a     = r_q[0];
	assign bsig1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
	assign bsig0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
	assign ch    = (e & r_q[5]) ^ (~e & r_q[6]);
	assign maj   = (a & r_q[1]) ^ (a & r_q[2]) ^ (r_q[1] & r_q[2]);
	assign s0    = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
		^ (w_q[1] >> 3);
	assign s1    = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		^ (w_q[14] >> 10);
	assign w_new = w_q[0] + s0 + w_q[9] + s1;
	assign t1    = r_q[7] + bsig1 + ch + round_k(rnd_q) + w_q[0];
	assign t2    = bsig0 + maj;
	assign ld_word = blk_q[ld_q];

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = ov_q;
	assign out_beat  = ob_q;
	assign pad_done_blk = (fill_q == 6'd63);

	// Block bytes and word schedule; payload, pad, zero and length bytes.
	// The block is kept as sixteen big-endian words, one byte lane written at a time.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop && q_data.has_byte) begin
					blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= q_data.data_byte;
				end
			end
			ST_PAD: begin
				if (!final_q) begin
					blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= PAD_BYTE;
				end else if (!spill_q && fill_q >= LEN_POS) begin
					blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <=
						bits_q[{~fill_q[2:0], 3'b000} +: 8];
				end else begin
					blk_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= 8'h00;
				end
			end
			ST_LOAD: begin
				w_q[ld_q] <= ld_word;
			end
			ST_ROUND: begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i+1];
				end
				w_q[15] <= w_new;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
				r_q[i] <= '0;
			end
			bits_q     <= '0;
			fill_q     <= '0;
			rnd_q      <= '0;
			ld_q       <= '0;
			final_q    <= 1'b0;
			spill_q    <= 1'b0;
			pend_end_q <= 1'b0;
			emit_q     <= '0;
			ov_q       <= 1'b0;
			ob_q       <= '0;
		end else begin
			if (ov_q && !out_stall && state_q != ST_EMIT) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						pend_end_q <= q_data.end_of_message;
						final_q    <= 1'b0;
						if (q_data.has_byte) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
							if (fill_q == 6'd63) begin
								ld_q    <= '0;
								state_q <= ST_LOAD;
							end else if (q_data.end_of_message) begin
								state_q <= ST_PAD;
							end
						end else if (q_data.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// The pad byte goes first, then zero or length bytes; a spill's second block has no pad byte.
					// A pad byte at or past the length slot leaves no room for the
					// length, so this block is zero filled and a second one follows.
					if (!final_q) begin
						spill_q <= (fill_q >= LEN_POS);
					end
					pend_end_q <= 1'b0;
					final_q    <= 1'b1;
					fill_q     <= fill_q + 6'd1;
					if (pad_done_blk) begin
						ld_q    <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					ld_q <= ld_q + 4'd1;
					if (ld_q == 4'd15) begin
						rnd_q <= '0;
						for (int i = 0; i < 8; i++) begin
							r_q[i] <= h_q[i];
						end
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					r_q[7] <= r_q[6];
					r_q[6] <= r_q[5];
					r_q[5] <= r_q[4];
					r_q[4] <= r_q[3] + t1;
					r_q[3] <= r_q[2];
					r_q[2] <= r_q[1];
					r_q[1] <= r_q[0];
					r_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + r_q[i];
					end
					if (pend_end_q) begin
						state_q <= ST_PAD;
					end else if (spill_q) begin
						// Fill has wrapped to zero; the second block carries the length.
						spill_q <= 1'b0;
						state_q <= ST_PAD;
					end else if (final_q) begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!ov_q || !out_stall) begin
						ov_q             <= 1'b1;
						ob_q.digest_word <= h_q[emit_q];
						ob_q.word_index  <= emit_q;
						ob_q.last_word   <= (emit_q == 3'd7);
						emit_q           <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= INIT_H[i];
							end
							bits_q  <= '0;
							fill_q  <= '0;
							final_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FOLD))
		else $error("round counter and state disagree");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (fill_q == 6'd0))
		else $error("digest emitted with a partial block");
	assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ($stable(ob_q) && ov_q))
		else $error("stalled digest beat changed");

endmodule

[rtl/sha256_byte_stream_hasher.sv]
// SHA-256 over a byte stream: front end queue plus compression back end.
// A byte that fills a block starts its compression: sixteen schedule loads,
// 64 rounds and a fold. An end beat adds padding (one or two blocks) and
// eight digest beats. While a block is padded or compressed the back end
// pops no beat; the queue keeps taking beats until it is full.
// Reset (arst_n, asynchronous, low) loads the initial hash values and clears
// the bit count and block fill.
module sha256_byte_stream_hasher import sha256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	// The front end is the queue: it takes a beat whenever it has room,
	// so the upstream side is stalled only when four beats already wait.
	logic     q_full;
	logic     q_empty;
	logic     q_pop;
	in_beat_t q_data;

	assign in_stall = q_full;

	sha256_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_valid && !q_full),
		.wr_data (in_data),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// The back end pulls one beat at a time and runs the block compression;
	// its digest register decouples it from the downstream stall.
	sha256_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_beat  (out_data),
		.out_stall (out_stall)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last_word) |-> (out_data.word_index == 3'd7))
		else $error("last word flag on wrong index");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("valid dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("stalled digest beat changed");

endmodule

[test/sha256_byte_stream_hasher_test.sv]
// Self-checking testbench for the SHA-256 byte stream hasher.
// Depends on sha256_pkg and sha256_byte_stream_hasher; a built-in SHA-256
// predictor works out every digest beat and checks it against the block.
module sha256_byte_stream_hasher_test;
	import sha256_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;

	sha256_byte_stream_hasher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Round constants for the predictor, held here as plain data.
	logic [31:0] sha_k [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Predictor state: running hash, bit count and the partial block.
	logic [31:0] run_hash [8];
	logic [63:0] run_bits;
	logic [7:0]  blk [64];
	int          blk_fill;

	in_beat_t  pending_beats [$];
	out_beat_t expected_words [$];

	int  errors;
	int  digests_seen;
	int  beats_sent;
	bit  hold_off;
	bit  quiet_in;
	bit  quiet_out;
	int  idle_cycles;

	function automatic logic [31:0] rotr(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] r [8];
		logic [31:0] t1, t2, x, y;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			x = w[i-15];
			y = w[i-2];
			w[i] = w[i-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[i-7]
				+ (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
		end
		r = run_hash;
		for (int i = 0; i < 64; i++) begin
			t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
				+ ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha_k[i] + w[i];
			t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
				+ ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
			r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
			r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			run_hash[i] += r[i];
	endtask

	task automatic restart_hash();
		for (int i = 0; i < 8; i++)
			run_hash[i] = INIT_H[i];
		run_bits = '0;
		blk_fill = 0;
	endtask

	// Applies one accepted input beat; queues eight digest beats on end of message.
	task automatic hash_beat(in_beat_t b);
		out_beat_t o;
		if (b.has_byte) begin
			blk[blk_fill] = b.data_byte;
			blk_fill++;
			run_bits += 64'd8;
			if (blk_fill == 64) begin
				compress_block();
				blk_fill = 0;
			end
		end
		if (!b.end_of_message)
			return;
		blk[blk_fill] = PAD_BYTE;
		blk_fill++;
		// Not enough room for the length: pad out and compress an extra block.
		if (blk_fill > LEN_POS) begin
			while (blk_fill < 64) begin
				blk[blk_fill] = 8'h00;
				blk_fill++;
			end
			compress_block();
			blk_fill = 0;
		end
		while (blk_fill < LEN_POS) begin
			blk[blk_fill] = 8'h00;
			blk_fill++;
		end
		for (int i = 0; i < 8; i++)
			blk[63-i] = run_bits[8*i +: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			o.digest_word = run_hash[i];
			o.word_index  = 3'(i);
			o.last_word   = (i == 7);
			expected_words.push_back(o);
		end
		restart_hash();
	endtask

	function automatic in_beat_t mk_beat(logic [7:0] d, logic hb, logic eom);
		in_beat_t b;
		b.data_byte      = d;
		b.has_byte       = hb;
		b.end_of_message = eom;
		return b;
	endfunction

	// Queues one message of the given length with random content, ending with
	// the end flag on the last byte or on a separate byteless beat.
	task automatic queue_message(int len);
		bit split_end;
		split_end = (len == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b1,
				!split_end && (i == len - 1)));
			// Occasional no-op beats inside a message.
			if ($urandom_range(0, 19) == 0)
				pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0));
		end
		if (split_end)
			pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1));
	endtask

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Driver: presents queued beats; a stalled beat is held unchanged.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				hash_beat(in_data);
				beats_sent <= beats_sent + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_beats.size() > 0 && (quiet_in || $urandom_range(0, 99) >= 11)) begin
					in_valid <= 1'b1;
					in_data  <= pending_beats.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted digest beat and drives the receiver stall.
	always @(posedge clk or negedge arst_n) begin
		out_beat_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected digest beat %h", $time, out_data);
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (out_data.digest_word !== want.digest_word) begin
						$display("%0t: digest_word expected %h actual %h", $time,
							want.digest_word, out_data.digest_word);
						errors++;
					end
					if (out_data.word_index !== want.word_index) begin
						$display("%0t: word_index expected %0d actual %0d", $time,
							want.word_index, out_data.word_index);
						errors++;
					end
					if (out_data.last_word !== want.last_word) begin
						$display("%0t: last_word expected %0b actual %0b", $time,
							want.last_word, out_data.last_word);
						errors++;
					end
					if (want.last_word)
						digests_seen++;
				end
			end
			out_stall <= hold_off || (!quiet_out && $urandom_range(0, 99) < 11);
		end
	end

	// Watchdog: counts cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Long receiver hold-off, counted in cycles here, while beats keep flowing in.
	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_off <= 1'b1;
		repeat (2000) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int plan_len;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_stall   = 1'b0;
		errors      = 0;
		digests_seen = 0;
		beats_sent  = 0;
		idle_cycles = 0;
		quiet_in    = 1'b0;
		quiet_out   = 1'b0;
		restart_hash();

		// Directed part: empty message, lone no-op, byte extremes, end on a
		// byte and on a separate beat, and lengths around the padding limits.
		pending_beats.push_back(mk_beat(8'hff, 1'b0, 1'b1));
		pending_beats.push_back(mk_beat(8'h00, 1'b0, 1'b0));
		pending_beats.push_back(mk_beat(8'h00, 1'b1, 1'b1));
		pending_beats.push_back(mk_beat(8'hff, 1'b1, 1'b1));
		pending_beats.push_back(mk_beat(8'h61, 1'b1, 1'b0));
		pending_beats.push_back(mk_beat(8'h62, 1'b1, 1'b0));
		pending_beats.push_back(mk_beat(8'h63, 1'b1, 1'b0));
		pending_beats.push_back(mk_beat(8'h00, 1'b0, 1'b1));
		queue_message(55);
		queue_message(56);
		queue_message(63);
		queue_message(64);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Random part: messages mostly short, a few past one or two blocks.
		while (beats_sent + pending_beats.size() < 500) begin
			case ($urandom_range(0, 9))
				0:       plan_len = $urandom_range(50, 130);
				1:       pending_beats.push_back(mk_beat(8'($urandom_range(0, 255)),
					1'b0, 1'b0));
				default: plan_len = $urandom_range(0, 20);
			endcase
			queue_message(plan_len);
		end

		// Stretch with no idling on either side once the hold-off is over.
		wait (beats_sent > 400);
		quiet_in  <= 1'b1;
		quiet_out <= 1'b1;
		wait (pending_beats.size() == 0 && !in_valid);
		quiet_in  <= 1'b0;
		quiet_out <= 1'b0;
		wait (expected_words.size() == 0);
		repeat (200) @(posedge clk);

		$display("Hashed %0d digests over %0d input beats, with stalls, gaps and a long",
			digests_seen, beats_sent);
		$display("receiver hold-off; messages spanned empty through multi-block lengths.");
		if (errors == 0 && expected_words.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
